// ===== rtl/bcd_clock_setting_fsm_top_macros.svh =====
// Assertion macros for the BCD clock-setting block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BCD_CLOCK_SETTING_FSM_TOP_MACROS_SVH
`define BCD_CLOCK_SETTING_FSM_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define BCSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define BCSF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BCSF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCSF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bcsf_pkg.sv =====
// Shared types, codes and BCD step functions for the clock-setting block.
// No dependencies; imported by every module of the block.
package bcsf_pkg;

  // Edit modes
  localparam logic [2:0] MODE_DISPLAY = 3'd0;
  localparam logic [2:0] MODE_DAY     = 3'd1;
  localparam logic [2:0] MODE_MONTH   = 3'd2;
  localparam logic [2:0] MODE_YEAR    = 3'd3;
  localparam logic [2:0] MODE_HOUR    = 3'd4;
  localparam logic [2:0] MODE_MIN     = 3'd5;
  localparam logic [2:0] MODE_SEC     = 3'd6;

  // Encoder turn codes
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // Months with 31 days, BCD, ascending
  localparam logic [4:0] LONG_MONTHS [7] = '{5'h01, 5'h03, 5'h05, 5'h07, 5'h08, 5'h10, 5'h12};

  typedef struct packed {
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [5:0] hours;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
  } bcd_clk_t;

  typedef struct packed {
    logic       key_press;
    logic [1:0] turn;
    bcd_clk_t   rtc;
  } item_t;

  typedef struct packed {
    logic [2:0] edit_mode;
    bcd_clk_t   cur;
    logic       cursor_on;
    logic       write_strobe;
  } result_t;

  // BCD byte to binary: low digit plus ten times high digit
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'b0, v[7:4]};
    return {4'b0, v[3:0]} + (hi << 3) + (hi << 1);
  endfunction

  // Binary 0..99 to BCD: quotient by reciprocal multiply
  function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [3:0]  q;
    logic [7:0]  r;
    prod = {8'b0, v} * 16'd205;
    q    = prod[14:11];
    r    = v - (({4'b0, q} << 3) + ({4'b0, q} << 1));
    return {q, r[3:0]};
  endfunction

  // Step with wrap between lo and hi; out-of-range values go to the wrap target
  function automatic logic [7:0] step_bin(input logic [7:0] v, input logic up,
                                          input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] res;
    if (up) begin
      res = (v >= hi || v < lo) ? lo : v + 8'd1;
    end else begin
      res = (v <= lo || v > hi) ? hi : v - 8'd1;
    end
    return res;
  endfunction

  function automatic logic [7:0] step_bcd(input logic [7:0] v, input logic up,
                                          input logic [7:0] lo, input logic [7:0] hi);
    return bin_to_bcd(step_bin(bcd_to_bin(v), up, lo, hi));
  endfunction

  // Year step on 29 February: land on the next multiple of four up, or the previous one down
  function automatic logic [7:0] leap_year_step(input logic [7:0] y, input logic up);
    logic [7:0] res;
    logic [7:0] ym1;
    ym1 = y - 8'd1;
    if (up) begin
      res = (y >= 8'd96) ? 8'd0 : {y[7:2] + 6'd1, 2'b00};
    end else begin
      res = (y == 8'd0 || y > 8'd99) ? 8'd96 : {ym1[7:2], 2'b00};
    end
    return res;
  endfunction

  // Month step while the day is 31: cycle through the long months only
  function automatic logic [4:0] long_month_step(input logic [4:0] m, input logic up);
    logic [4:0] res;
    logic       hit;
    logic [7:0] mb;
    logic [7:0] lb;
    int         i;
    res = up ? LONG_MONTHS[0] : LONG_MONTHS[6];
    hit = 1'b0;
    mb  = bcd_to_bin({3'b0, m});
    for (i = 0; i < 7; i++) begin
      if (LONG_MONTHS[i] == m) begin
        hit = 1'b1;
        res = up ? LONG_MONTHS[(i == 6) ? 0 : i + 1] : LONG_MONTHS[(i == 0) ? 6 : i - 1];
      end
    end
    if (!hit) begin
      if (up) begin
        // lowest listed month above wins: scan downward
        for (i = 6; i >= 0; i--) begin
          lb = bcd_to_bin({3'b0, LONG_MONTHS[i]});
          if (lb > mb) res = LONG_MONTHS[i];
        end
      end else begin
        // highest listed month below wins: scan upward
        for (i = 0; i < 7; i++) begin
          lb = bcd_to_bin({3'b0, LONG_MONTHS[i]});
          if (lb < mb) res = LONG_MONTHS[i];
        end
      end
    end
    return res;
  endfunction

  // Month fix-up after a day step
  function automatic logic [4:0] day_fix_month(input logic [5:0] d, input logic [4:0] m,
                                               input logic up);
    logic [4:0] res;
    res = m;
    if (d == 6'h30 && m == 5'h02) res = 5'h03;
    if (d == 6'h31) begin
      case (res)
        5'h02:   res = up ? 5'h03 : 5'h01;
        5'h04:   res = up ? 5'h05 : 5'h03;
        5'h06:   res = up ? 5'h07 : 5'h05;
        5'h09:   res = up ? 5'h10 : 5'h08;
        5'h11:   res = up ? 5'h12 : 5'h10;
        default: res = res;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== rtl/bcsf_in_reg.sv =====
// Input register stage: captures one update beat and holds it until the core takes it.
// Depends on bcsf_pkg for the item type.
module bcsf_in_reg
  import bcsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  fire,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // Free when empty or when the held beat leaves this cycle
  assign in_ready  = !valid_r || fire;
  assign accept    = in_valid && in_ready;
  assign valid_nxt = accept || (valid_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/bcsf_core.sv =====
// Clock-setting state machine: mode and held date/time registers with BCD step logic.
// Depends on bcsf_pkg and the assertion macro header.
`include "bcd_clock_setting_fsm_top_macros.svh"
module bcsf_core
  import bcsf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t res_nxt
);

  logic [2:0] mode_r, mode_nxt;
  bcd_clk_t   tm_r, tm_nxt;
  logic       wr_nxt;

  logic       has_turn;
  logic       up;
  logic [7:0] day_stp8;
  logic [5:0] day_stp;
  logic [4:0] mon_fix;
  logic [7:0] mon_stp8;
  logic [4:0] mon_long;
  logic [7:0] ybin;
  logic [7:0] ystep;
  logic [7:0] ybcd;
  logic [7:0] hr_stp8;
  logic [7:0] min_stp8;
  logic [7:0] sec_stp8;

  // Candidate steps for every field
  always_comb begin
    has_turn = (item.turn == TURN_LEFT) || (item.turn == TURN_RIGHT);
    up       = (item.turn == TURN_RIGHT);
    day_stp8 = step_bcd({2'b0, tm_r.day}, up, 8'd1, 8'd31);
    day_stp  = day_stp8[5:0];
    mon_fix  = day_fix_month(day_stp, tm_r.month, up);
    mon_stp8 = step_bcd({3'b0, tm_r.month}, up, 8'd1, 8'd12);
    mon_long = long_month_step(tm_r.month, up);
    ybin     = bcd_to_bin(tm_r.year);
    if (tm_r.month == 5'h02 && tm_r.day == 6'h29) begin
      ystep = leap_year_step(ybin, up);
    end else begin
      ystep = step_bin(ybin, up, 8'd0, 8'd99);
    end
    ybcd     = bin_to_bcd(ystep);
    hr_stp8  = step_bcd({2'b0, tm_r.hours}, up, 8'd0, 8'd23);
    min_stp8 = step_bcd({1'b0, tm_r.minutes}, up, 8'd0, 8'd59);
    sec_stp8 = step_bcd({1'b0, tm_r.seconds}, up, 8'd0, 8'd59);
  end

  // Next mode and held values
  always_comb begin
    mode_nxt = mode_r;
    tm_nxt   = tm_r;
    wr_nxt   = 1'b0;
    if (mode_r == MODE_DISPLAY || mode_r > MODE_SEC) begin
      tm_nxt   = item.rtc;
      mode_nxt = item.key_press ? MODE_DAY : MODE_DISPLAY;
    end else if (mode_r == MODE_SEC && item.key_press) begin
      wr_nxt   = 1'b1;
      mode_nxt = MODE_DISPLAY;
    end else begin
      if (item.key_press) mode_nxt = mode_r + 3'd1;
      if (has_turn) begin
        case (mode_r)
          MODE_DAY: begin
            tm_nxt.day   = day_stp;
            tm_nxt.month = mon_fix;
          end
          MODE_MONTH: begin
            tm_nxt.month = (tm_r.day == 6'h31) ? mon_long : mon_stp8[4:0];
          end
          MODE_YEAR: begin
            tm_nxt.year = ybcd;
          end
          MODE_HOUR: begin
            tm_nxt.hours = hr_stp8[5:0];
          end
          MODE_MIN: begin
            tm_nxt.minutes = min_stp8[6:0];
          end
          default: begin
            tm_nxt.seconds = sec_stp8[6:0];
          end
        endcase
      end
    end
  end

  // Advance state on each beat the core takes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DISPLAY;
      tm_r   <= '{seconds: 7'h00, minutes: 7'h00, hours: 6'h00,
                  day: 6'h01, month: 5'h01, year: 8'h00};
    end else if (fire) begin
      mode_r <= mode_nxt;
      tm_r   <= tm_nxt;
    end
  end

  assign res_nxt.edit_mode    = mode_nxt;
  assign res_nxt.cur          = tm_nxt;
  assign res_nxt.cursor_on    = (mode_nxt != MODE_DISPLAY);
  assign res_nxt.write_strobe = wr_nxt;

  `BCSF_ASSERT_NXT(a_strobe_ends_edit, clk, rst_n, rst_n && fire && res_nxt.write_strobe, mode_r == MODE_DISPLAY)
  `BCSF_ASSERT_NXT(a_idle_holds, clk, rst_n, rst_n && !fire, $stable(mode_r) && $stable(tm_r))
  `BCSF_ASSERT_IMP(a_strobe_from_sec, clk, rst_n, fire && res_nxt.write_strobe, mode_r == MODE_SEC && item.key_press)

endmodule

// ===== rtl/bcsf_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
// Depends on bcsf_pkg for the result type.
module bcsf_out_reg
  import bcsf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    out_free,
  output result_t res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Slot is free when empty or drained this cycle
  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = fire || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load result on each core beat
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/bcd_clock_setting_fsm_top.sv =====
// Channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | key_press, turn, rtc_* (BCD date and time)
// out     | out | out_valid / out_ready | edit_mode, cur_*, cursor_on, write_strobe
//
// One update beat per cycle sustained while the output is ready; the core logic between
// the input register and the result register is combinational. An accepted beat is held in
// the input register, then loaded into the result register once that slot is free.
// Synchronous active-low reset puts the block in display mode with 01-01-00 00:00:00.
// A stalled output holds its beat; the input register still takes one more beat behind it.
// Top level of the BCD clock-setting block; depends on bcsf_pkg and the bcsf_* modules.
module bcd_clock_setting_fsm_top
  import bcsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_key_press,
  input  logic [1:0] in_turn,
  input  logic [6:0] in_rtc_seconds,
  input  logic [6:0] in_rtc_minutes,
  input  logic [5:0] in_rtc_hours,
  input  logic [5:0] in_rtc_day,
  input  logic [4:0] in_rtc_month,
  input  logic [7:0] in_rtc_year,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_edit_mode,
  output logic [6:0] out_cur_seconds,
  output logic [6:0] out_cur_minutes,
  output logic [5:0] out_cur_hours,
  output logic [5:0] out_cur_day,
  output logic [4:0] out_cur_month,
  output logic [7:0] out_cur_year,
  output logic       out_cursor_on,
  output logic       out_write_strobe
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    out_free;
  logic    fire;
  result_t res_nxt;
  result_t res;

  // Pack input ports
  assign in_item.key_press   = in_key_press;
  assign in_item.turn        = in_turn;
  assign in_item.rtc.seconds = in_rtc_seconds;
  assign in_item.rtc.minutes = in_rtc_minutes;
  assign in_item.rtc.hours   = in_rtc_hours;
  assign in_item.rtc.day     = in_rtc_day;
  assign in_item.rtc.month   = in_rtc_month;
  assign in_item.rtc.year    = in_rtc_year;

  // Core takes a held beat whenever the result slot can accept it
  assign fire = item_valid && out_free;

  bcsf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  bcsf_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item),
    .res_nxt (res_nxt)
  );

  bcsf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_in    (res_nxt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_free  (out_free),
    .res       (res)
  );

  // Unpack result
  assign out_edit_mode    = res.edit_mode;
  assign out_cur_seconds  = res.cur.seconds;
  assign out_cur_minutes  = res.cur.minutes;
  assign out_cur_hours    = res.cur.hours;
  assign out_cur_day      = res.cur.day;
  assign out_cur_month    = res.cur.month;
  assign out_cur_year     = res.cur.year;
  assign out_cursor_on    = res.cursor_on;
  assign out_write_strobe = res.write_strobe;

endmodule

// ===== test/bcsf_setting_checker.sv =====
// Scoreboard for the BCD clock-setting block: follows the edit state from accepted
// update beats, predicts each result beat and compares it field by field.
// Depends on bcsf_pkg for the mode and turn codes and the beat layouts.
`timescale 1ns / 100ps

module bcsf_setting_checker
  import bcsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_key_press,
  input  logic [1:0] in_turn,
  input  logic [6:0] in_rtc_seconds,
  input  logic [6:0] in_rtc_minutes,
  input  logic [5:0] in_rtc_hours,
  input  logic [5:0] in_rtc_day,
  input  logic [4:0] in_rtc_month,
  input  logic [7:0] in_rtc_year,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_edit_mode,
  input  logic [6:0] out_cur_seconds,
  input  logic [6:0] out_cur_minutes,
  input  logic [5:0] out_cur_hours,
  input  logic [5:0] out_cur_day,
  input  logic [4:0] out_cur_month,
  input  logic [7:0] out_cur_year,
  input  logic       out_cursor_on,
  input  logic       out_write_strobe,
  output int         fail_cnt,
  output int         pending_cnt,
  output int         checked_cnt,
  output int         write_cnt
);

  localparam int MAX_PRINTS = 50;

  // Predicted edit state and held date/time
  logic [2:0] edit_state = MODE_DISPLAY;
  bcd_clk_t   held = '{7'h00, 7'h00, 6'h00, 6'h01, 5'h01, 8'h00};
  result_t    setting_q[$];
  int         faults = 0;
  int         checked = 0;
  int         writes = 0;

  task automatic report_fault(string msg);
    faults++;
    if (faults <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_fault($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // BCD digits read as tens and units, whatever their range
  function automatic int dec_of(logic [7:0] b);
    return b[3:0] + 10 * b[7:4];
  endfunction

  function automatic logic [7:0] bcd_of(int v);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  // Wrap between limits; anything out of range lands on the wrap target
  function automatic int wrap_step(int v, bit up, int lo, int hi);
    if (up) return (v >= hi || v < lo) ? lo : v + 1;
    return (v <= lo || v > hi) ? hi : v - 1;
  endfunction

  function automatic logic [7:0] bcd_step(logic [7:0] b, bit up, int lo, int hi);
    return bcd_of(wrap_step(dec_of(b), up, lo, hi));
  endfunction

  function automatic bit is_short_month(logic [4:0] m);
    case (m)
      5'h02, 5'h04, 5'h06, 5'h09, 5'h11: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Day step, then push the month off an impossible date
  function automatic void turn_day(bit up);
    int m;
    held.day = 6'(bcd_step({2'b0, held.day}, up, 1, 31));
    if (held.day == 6'h30 && held.month == 5'h02) held.month = 5'h03;
    if (held.day == 6'h31 && is_short_month(held.month)) begin
      m = dec_of({3'b0, held.month});
      held.month = 5'(bcd_of(up ? m + 1 : m - 1));
    end
  endfunction

  // Month step; on day 31 only the long months are reachable
  function automatic void turn_month(bit up);
    int  m;
    int  pos;
    int  i;
    bit  found;
    if (held.day != 6'h31) begin
      held.month = 5'(bcd_step({3'b0, held.month}, up, 1, 12));
    end else begin
      pos = -1;
      for (i = 0; i < 7; i++) begin
        if (LONG_MONTHS[i] == held.month) pos = i;
      end
      if (pos >= 0) begin
        held.month = LONG_MONTHS[up ? (pos + 1) % 7 : (pos + 6) % 7];
      end else begin
        m = dec_of({3'b0, held.month});
        found = 1'b0;
        if (up) begin
          held.month = LONG_MONTHS[0];
          for (i = 0; i < 7; i++) begin
            if (!found && dec_of({3'b0, LONG_MONTHS[i]}) > m) begin
              held.month = LONG_MONTHS[i];
              found = 1'b1;
            end
          end
        end else begin
          held.month = LONG_MONTHS[6];
          for (i = 6; i >= 0; i--) begin
            if (!found && dec_of({3'b0, LONG_MONTHS[i]}) < m) begin
              held.month = LONG_MONTHS[i];
              found = 1'b1;
            end
          end
        end
      end
    end
  endfunction

  // Year step; on 29 February keep stepping to a leap year
  function automatic void turn_year(bit up);
    int y;
    int n;
    y = dec_of(held.year);
    if (held.month == 5'h02 && held.day == 6'h29) begin
      n = 0;
      do begin
        y = wrap_step(y, up, 0, 99);
        n++;
      end while (y % 4 != 0 && n < 8);
    end else begin
      y = wrap_step(y, up, 0, 99);
    end
    held.year = bcd_of(y);
  endfunction

  // Advance the edit state by one update and build the expected result beat
  function automatic result_t take_update(logic key, logic [1:0] turn, bcd_clk_t rtc);
    result_t    r;
    logic [2:0] was;
    bit         up;
    bit         moved;
    bit         wr;
    was   = edit_state;
    up    = (turn == TURN_RIGHT);
    moved = (turn == TURN_LEFT || turn == TURN_RIGHT);
    wr    = 1'b0;
    if (was == MODE_DISPLAY || was > MODE_SEC) begin
      held       = rtc;
      edit_state = key ? MODE_DAY : MODE_DISPLAY;
    end else if (was == MODE_SEC && key) begin
      wr         = 1'b1;
      edit_state = MODE_DISPLAY;
    end else begin
      if (key) edit_state = was + 3'd1;
      if (moved) begin
        case (was)
          MODE_DAY:   turn_day(up);
          MODE_MONTH: turn_month(up);
          MODE_YEAR:  turn_year(up);
          MODE_HOUR:  held.hours = 6'(bcd_step({2'b0, held.hours}, up, 0, 23));
          MODE_MIN:   held.minutes = 7'(bcd_step({1'b0, held.minutes}, up, 0, 59));
          default:    held.seconds = 7'(bcd_step({1'b0, held.seconds}, up, 0, 59));
        endcase
      end
    end
    r.edit_mode    = edit_state;
    r.cur          = held;
    r.cursor_on    = (edit_state != MODE_DISPLAY);
    r.write_strobe = wr;
    return r;
  endfunction

  // Predict on each accepted update, compare on each accepted result
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      edit_state = MODE_DISPLAY;
      held       = '{7'h00, 7'h00, 6'h00, 6'h01, 5'h01, 8'h00};
      setting_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        setting_q.push_back(take_update(in_key_press, in_turn,
          {in_rtc_seconds, in_rtc_minutes, in_rtc_hours, in_rtc_day, in_rtc_month,
           in_rtc_year}));
      end
      if (out_valid && out_ready) begin
        got = {out_edit_mode, out_cur_seconds, out_cur_minutes, out_cur_hours, out_cur_day,
               out_cur_month, out_cur_year, out_cursor_on, out_write_strobe};
        checked++;
        if (setting_q.size() == 0) begin
          report_fault("result beat with no update waiting");
        end else begin
          want = setting_q.pop_front();
          check_field("edit_mode", {5'b0, got.edit_mode}, {5'b0, want.edit_mode});
          check_field("cur_seconds", {1'b0, got.cur.seconds}, {1'b0, want.cur.seconds});
          check_field("cur_minutes", {1'b0, got.cur.minutes}, {1'b0, want.cur.minutes});
          check_field("cur_hours", {2'b0, got.cur.hours}, {2'b0, want.cur.hours});
          check_field("cur_day", {2'b0, got.cur.day}, {2'b0, want.cur.day});
          check_field("cur_month", {3'b0, got.cur.month}, {3'b0, want.cur.month});
          check_field("cur_year", got.cur.year, want.cur.year);
          check_field("cursor_on", {7'b0, got.cursor_on}, {7'b0, want.cursor_on});
          check_field("write_strobe", {7'b0, got.write_strobe}, {7'b0, want.write_strobe});
          if (want.write_strobe) writes++;
        end
      end
    end
    fail_cnt    <= faults;
    pending_cnt <= setting_q.size();
    checked_cnt <= checked;
    write_cnt   <= writes;
  end

endmodule

// ===== test/tb_bcd_clock_setting_fsm_top.sv =====
// Testbench top for the BCD clock-setting block: drives update beats in bursts,
// stalls the result side, and gives the verdict from bcsf_setting_checker.
// Depends on bcsf_pkg, bcd_clock_setting_fsm_top and bcsf_setting_checker.
`timescale 1ns / 100ps

module tb_bcd_clock_setting_fsm_top;
  import bcsf_pkg::*;

  localparam int ITEM_TARGET  = 1900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRESSURE_AT  = 700;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_key_press;
  logic [1:0] in_turn;
  logic [6:0] in_rtc_seconds;
  logic [6:0] in_rtc_minutes;
  logic [5:0] in_rtc_hours;
  logic [5:0] in_rtc_day;
  logic [4:0] in_rtc_month;
  logic [7:0] in_rtc_year;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_edit_mode;
  logic [6:0] out_cur_seconds;
  logic [6:0] out_cur_minutes;
  logic [5:0] out_cur_hours;
  logic [5:0] out_cur_day;
  logic [4:0] out_cur_month;
  logic [7:0] out_cur_year;
  logic       out_cursor_on;
  logic       out_write_strobe;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int write_cnt;
  int cycle_cnt = 0;
  int beats_sent = 0;
  int burst_left = 0;

  // Edit mode as the sender sees it, to shape sessions
  logic [2:0] ui_mode = MODE_DISPLAY;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bcd_clock_setting_fsm_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_press     (in_key_press),
    .in_turn          (in_turn),
    .in_rtc_seconds   (in_rtc_seconds),
    .in_rtc_minutes   (in_rtc_minutes),
    .in_rtc_hours     (in_rtc_hours),
    .in_rtc_day       (in_rtc_day),
    .in_rtc_month     (in_rtc_month),
    .in_rtc_year      (in_rtc_year),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edit_mode    (out_edit_mode),
    .out_cur_seconds  (out_cur_seconds),
    .out_cur_minutes  (out_cur_minutes),
    .out_cur_hours    (out_cur_hours),
    .out_cur_day      (out_cur_day),
    .out_cur_month    (out_cur_month),
    .out_cur_year     (out_cur_year),
    .out_cursor_on    (out_cursor_on),
    .out_write_strobe (out_write_strobe)
  );

  bcsf_setting_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_key_press     (in_key_press),
    .in_turn          (in_turn),
    .in_rtc_seconds   (in_rtc_seconds),
    .in_rtc_minutes   (in_rtc_minutes),
    .in_rtc_hours     (in_rtc_hours),
    .in_rtc_day       (in_rtc_day),
    .in_rtc_month     (in_rtc_month),
    .in_rtc_year      (in_rtc_year),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edit_mode    (out_edit_mode),
    .out_cur_seconds  (out_cur_seconds),
    .out_cur_minutes  (out_cur_minutes),
    .out_cur_hours    (out_cur_hours),
    .out_cur_day      (out_cur_day),
    .out_cur_month    (out_cur_month),
    .out_cur_year     (out_cur_year),
    .out_cursor_on    (out_cursor_on),
    .out_write_strobe (out_write_strobe),
    .fail_cnt         (fail_cnt),
    .pending_cnt      (pending_cnt),
    .checked_cnt      (checked_cnt),
    .write_cnt        (write_cnt)
  );

  function automatic bcd_clk_t rtc_of(logic [7:0] s, logic [7:0] mi, logic [7:0] h,
                                      logic [7:0] d, logic [7:0] mo, logic [7:0] y);
    return {s[6:0], mi[6:0], h[5:0], d[5:0], mo[4:0], y};
  endfunction

  function automatic bcd_clk_t any_rtc();
    return {7'($urandom), 7'($urandom), 6'($urandom), 6'($urandom), 5'($urandom),
            8'($urandom)};
  endfunction

  function automatic logic [7:0] pick_bcd(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  // Plausible date, leaning on month ends and February
  function automatic bcd_clk_t likely_rtc();
    bcd_clk_t r;
    r.seconds = 7'(pick_bcd(0, 59));
    r.minutes = 7'(pick_bcd(0, 59));
    r.hours   = 6'(pick_bcd(0, 23));
    case ($urandom_range(0, 5))
      0:       r.day = 6'h28;
      1:       r.day = 6'h29;
      2:       r.day = 6'h30;
      3:       r.day = 6'h31;
      default: r.day = 6'(pick_bcd(1, 31));
    endcase
    case ($urandom_range(0, 3))
      0: r.month = 5'h02;
      1: begin
        case ($urandom_range(0, 3))
          0:       r.month = 5'h04;
          1:       r.month = 5'h06;
          2:       r.month = 5'h09;
          default: r.month = 5'h11;
        endcase
      end
      default: r.month = 5'(pick_bcd(1, 12));
    endcase
    r.year = pick_bcd(0, 99);
    return r;
  endfunction

  // Offer one update beat; open a random gap when the current burst runs out
  task automatic offer_update(logic key, logic [1:0] turn, bcd_clk_t rtc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_key_press   <= key;
    in_turn        <= turn;
    in_rtc_seconds <= rtc.seconds;
    in_rtc_minutes <= rtc.minutes;
    in_rtc_hours   <= rtc.hours;
    in_rtc_day     <= rtc.day;
    in_rtc_month   <= rtc.month;
    in_rtc_year    <= rtc.year;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (key) begin
      if (ui_mode == MODE_DISPLAY) ui_mode = MODE_DAY;
      else if (ui_mode == MODE_SEC) ui_mode = MODE_DISPLAY;
      else ui_mode = ui_mode + 3'd1;
    end
  endtask

  // Stall the result side in stretches; hold off once for a long stretch
  initial begin : result_sink
    int  run_len;
    int  style;
    int  hold;
    bit  pressure_done;
    pressure_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && cycle_cnt >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
      end
      run_len = $urandom_range(8, 80);
      style   = $urandom_range(0, 3);
      repeat (run_len) begin
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, pending_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [1:0] turn;
    int         r;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_key_press   <= 1'b0;
    in_turn        <= 2'd0;
    in_rtc_seconds <= '0;
    in_rtc_minutes <= '0;
    in_rtc_hours   <= '0;
    in_rtc_day     <= '0;
    in_rtc_month   <= '0;
    in_rtc_year    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // 29 February session: enter with a turn in display (ignored), Feb 30 rolls to March,
    // then back to February and leap-year jumps on the year
    offer_update(1'b1, TURN_RIGHT, rtc_of(8'h00, 8'h00, 8'h23, 8'h29, 8'h02, 8'h97));
    offer_update(1'b0, TURN_RIGHT, any_rtc());
    offer_update(1'b0, TURN_LEFT, any_rtc());
    offer_update(1'b1, 2'd3, any_rtc());
    offer_update(1'b0, TURN_LEFT, any_rtc());
    offer_update(1'b1, 2'd0, any_rtc());
    offer_update(1'b0, TURN_RIGHT, any_rtc());
    offer_update(1'b0, TURN_LEFT, any_rtc());
    offer_update(1'b1, TURN_RIGHT, any_rtc());
    offer_update(1'b1, TURN_RIGHT, any_rtc());
    offer_update(1'b1, TURN_LEFT, any_rtc());
    // final press with a turn: turn dropped, strobe raised
    offer_update(1'b1, TURN_LEFT, any_rtc());

    // Day 31 in a short month, then out-of-range hour, minute, second and year
    offer_update(1'b1, 2'd0, rtc_of(8'h7f, 8'h7f, 8'h3f, 8'h31, 8'h04, 8'hff));
    offer_update(1'b1, 2'd0, any_rtc());
    offer_update(1'b0, TURN_RIGHT, any_rtc());
    offer_update(1'b1, TURN_LEFT, any_rtc());
    offer_update(1'b1, TURN_LEFT, any_rtc());
    offer_update(1'b1, TURN_RIGHT, any_rtc());
    offer_update(1'b1, TURN_LEFT, any_rtc());
    offer_update(1'b0, TURN_RIGHT, any_rtc());
    offer_update(1'b1, 2'd0, any_rtc());

    // September 30 stepped to 31 carries the month into October; random part takes over
    offer_update(1'b1, 2'd3, rtc_of(8'h00, 8'h00, 8'h00, 8'h30, 8'h09, 8'h00));
    offer_update(1'b0, TURN_RIGHT, any_rtc());

    // Mostly full edit sessions with random turns; some idle noise in display
    while (beats_sent < ITEM_TARGET) begin
      if (ui_mode == MODE_DISPLAY) begin
        if ($urandom_range(0, 3) == 0) begin
          offer_update(1'b0, 2'($urandom), any_rtc());
        end else begin
          offer_update(1'b1, 2'($urandom),
                       ($urandom_range(0, 4) == 0) ? any_rtc() : likely_rtc());
        end
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4) turn = TURN_LEFT;
        else if (r < 8) turn = TURN_RIGHT;
        else if (r == 8) turn = 2'd0;
        else turn = 2'd3;
        offer_update(($urandom_range(0, 3) == 0), turn, any_rtc());
      end
    end
    in_valid <= 1'b0;

    // Drain the results once the last beat shows in the count, then watch for strays
    do @(posedge clk); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d update beats, checked %0d results, %0d edited settings written back.",
             beats_sent, checked_cnt, write_cnt);
    $display("Covered month-end and leap-day edits, bursty input and a %0d-cycle output stall.",
             LONG_HOLD);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bcsf_pkg.sv
rtl/bcsf_in_reg.sv
rtl/bcsf_core.sv
rtl/bcsf_out_reg.sv
rtl/bcd_clock_setting_fsm_top.sv
test/bcsf_setting_checker.sv
test/tb_bcd_clock_setting_fsm_top.sv
